@@ rtl/tpc_pkg.sv @@
`default_nettype none

package tpc_pkg;

  // width of the curvature word and of the root search
  localparam int OUT_W = 32;

  // multiplier digit: bits of the second operand folded in per stage
  localparam int MUL_DIGIT = 8;

  // output tuser bit positions
  localparam int USER_DEGENERATE = 0;
  localparam int USER_SATURATED  = 1;
  localparam int USER_W          = 2;

  typedef struct packed {
    logic neg;
    logic deg;
  } tpc_flags_t;

endpackage

`default_nettype wire

@@ rtl/tpc_mul.sv @@
`default_nettype none

// unsigned pipelined multiplier, one digit of b per stage, side data rides along
module tpc_mul
  import tpc_pkg::*;
#(
  parameter int AW     = 8,
  parameter int BW     = 8,
  parameter int DB     = MUL_DIGIT,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [AW-1:0]     a_i,
  input  wire logic [BW-1:0]     b_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [AW+BW-1:0]       p_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int NS  = (BW + DB - 1) / DB;
  localparam int BPW = NS * DB;
  localparam int PW  = AW + BW;

  logic [PW-1:0]     acc_q  [NS];
  logic [AW-1:0]     a_q    [NS];
  logic [BPW-1:0]    b_q    [NS];
  logic [SIDE_W-1:0] side_q [NS];
  logic              vld_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [PW-1:0]     acc_in;
    logic [AW-1:0]     a_in;
    logic [BPW-1:0]    b_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [AW+DB-1:0]  pp;

    if (k == 0) begin : g_first
      assign acc_in  = '0;
      assign a_in    = a_i;
      assign b_in    = BPW'(b_i);
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign acc_in  = acc_q[k-1];
      assign a_in    = a_q[k-1];
      assign b_in    = b_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign pp = a_in * b_in[k*DB +: DB];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k]  <= acc_in + (PW'(pp) << (k * DB));
        a_q[k]    <= a_in;
        b_q[k]    <= b_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign p_o     = acc_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

@@ rtl/three_point_curvature.sv @@
// three point curvature: signed curvature k = (x'y'' - x''y') / (x'^2 + y'^2)^1.5
// of a path, from a window of three points, as a Q8.24 word (FRAC_BITS fraction).
// input channel s_axis: one beat per window; tdata holds first_x, first_y, mid_x,
// mid_y, last_x, last_y from the lowest bit up, tuser is at_start (first
// difference taken as mid - first instead of last - mid).
// output channel m_axis: one beat per window, in order; tdata is the curvature,
// tuser bit 0 degenerate (zero first difference, curvature 0), bit 1 saturated.
// the magnitude is exact: the largest q with q^2 * s^3 <= (|num| * 2^F)^2,
// truncated toward zero, then clamped to the signed 32-bit range.
// throughput: one window per cycle while the output is not stalled. stages: 3 front
// stages, three digit-serial multipliers (s*s, s^2*s, X*X, ceil(width/8) stages
// each), a 32 stage bit-wise root search and the output register.
// every stage advances together while the output register is empty or taken;
// while the receiver stalls a full output, the whole pipe holds and s_axis
// tready is low, nothing is dropped or repeated.
// reset clears all valid bits; the pipe is empty and ready right after reset.
`default_nettype none

module three_point_curvature
  import tpc_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 24,
  localparam int InTdw     = ((6 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // first_x, first_y, mid_x, mid_y, last_x, last_y, zero fill
  input  wire logic [InTdw-1:0]  s_axis_tdata_i,
  // at_start
  input  wire logic              s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // curvature
  output logic [OUT_W-1:0]       m_axis_tdata_o,
  // degenerate, saturated
  output logic [USER_W-1:0]      m_axis_tuser_o
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;          // first difference
  localparam int EW   = C + 2;          // second difference
  localparam int PW   = DW + EW;        // cross products
  localparam int NUMW = PW + 1;         // signed numerator
  localparam int MAGW = PW;             // numerator magnitude
  localparam int SQW  = 2 * DW;         // squares of the first difference
  localparam int SW   = 2 * C + 2;      // s = dx^2 + dy^2
  localparam int S2W  = 2 * SW;
  localparam int MW   = 3 * SW;         // s^3
  localparam int XW   = MAGW + FRAC_BITS;
  localparam int X2W  = 2 * XW;
  localparam int QMW  = MW + OUT_W;     // q * s^3
  localparam int TWA  = MW + 2 * OUT_W + 2;
  localparam int TW   = (X2W + 1 > TWA) ? X2W + 1 : TWA;

  // whole pipe moves together
  logic ce;
  logic out_vld_q;

  assign ce              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = ce;

  // stage 1: differences
  logic signed [C-1:0]  fx, fy, mx, my, lx, ly;
  logic signed [DW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [EW-1:0] ex_d, ey_d, ex_q, ey_q;
  logic                 vld1_q;

  assign fx = s_axis_tdata_i[0*C +: C];
  assign fy = s_axis_tdata_i[1*C +: C];
  assign mx = s_axis_tdata_i[2*C +: C];
  assign my = s_axis_tdata_i[3*C +: C];
  assign lx = s_axis_tdata_i[4*C +: C];
  assign ly = s_axis_tdata_i[5*C +: C];

  always_comb begin
    if (s_axis_tuser_i) begin
      dx_d = DW'(mx) - DW'(fx);
      dy_d = DW'(my) - DW'(fy);
    end else begin
      dx_d = DW'(lx) - DW'(mx);
      dy_d = DW'(ly) - DW'(my);
    end
    ex_d = EW'(fx) + EW'(lx) - (EW'(mx) <<< 1);
    ey_d = EW'(fy) + EW'(ly) - (EW'(my) <<< 1);
  end

  // stage 2: products
  logic signed [PW-1:0]  p1_d, p2_d, p1_q, p2_q;
  logic signed [SQW-1:0] sx_d, sy_d, sx_q, sy_q;
  logic                  deg2_q, vld2_q;

  assign p1_d = dx_q * ey_q;
  assign p2_d = ex_q * dy_q;
  assign sx_d = dx_q * dx_q;
  assign sy_d = dy_q * dy_q;

  // stage 3: numerator magnitude and s
  logic signed [NUMW-1:0] num;
  logic [MAGW-1:0]        mag_d, mag3_q;
  logic [SW-1:0]          s_d, s3_q;
  tpc_flags_t             flags3_q;
  logic                   neg_d, vld3_q;

  always_comb begin
    num   = NUMW'(p1_q) - NUMW'(p2_q);
    neg_d = num[NUMW-1];
    mag_d = neg_d ? MAGW'(-num) : MAGW'(num);
    s_d   = SW'(sx_q) + SW'(sy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (ce) begin
      vld1_q <= s_axis_tvalid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      ex_q         <= ex_d;
      ey_q         <= ey_d;
      p1_q         <= p1_d;
      p2_q         <= p2_d;
      sx_q         <= sx_d;
      sy_q         <= sy_d;
      deg2_q       <= (dx_q == '0) && (dy_q == '0);
      mag3_q       <= mag_d;
      s3_q         <= s_d;
      flags3_q.neg <= neg_d;
      flags3_q.deg <= deg2_q;
    end
  end

  // s^2
  logic [S2W-1:0]  s2;
  logic [SW-1:0]   sa_s;
  logic [MAGW-1:0] sa_mag;
  tpc_flags_t      sa_flags;
  logic            sa_vld;

  tpc_mul #(
    .AW     (SW),
    .BW     (SW),
    .SIDE_W (SW + MAGW + $bits(tpc_flags_t))
  ) u_mul_s2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ce),
    .valid_i (vld3_q),
    .a_i     (s3_q),
    .b_i     (s3_q),
    .side_i  ({s3_q, mag3_q, flags3_q}),
    .valid_o (sa_vld),
    .p_o     (s2),
    .side_o  ({sa_s, sa_mag, sa_flags})
  );

  // s^3
  logic [MW-1:0]   s3cube;
  logic [MAGW-1:0] sb_mag;
  tpc_flags_t      sb_flags;
  logic            sb_vld;

  tpc_mul #(
    .AW     (S2W),
    .BW     (SW),
    .SIDE_W (MAGW + $bits(tpc_flags_t))
  ) u_mul_s3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ce),
    .valid_i (sa_vld),
    .a_i     (s2),
    .b_i     (sa_s),
    .side_i  ({sa_mag, sa_flags}),
    .valid_o (sb_vld),
    .p_o     (s3cube),
    .side_o  ({sb_mag, sb_flags})
  );

  // (|num| * 2^F)^2
  logic [XW-1:0]  xval;
  logic [X2W-1:0] x2;
  logic [MW-1:0]  sc_m;
  tpc_flags_t     sc_flags;
  logic           sc_vld;

  assign xval = {sb_mag, {FRAC_BITS{1'b0}}};

  tpc_mul #(
    .AW     (XW),
    .BW     (XW),
    .SIDE_W (MW + $bits(tpc_flags_t))
  ) u_mul_x2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ce),
    .valid_i (sb_vld),
    .a_i     (xval),
    .b_i     (xval),
    .side_i  ({s3cube, sb_flags}),
    .valid_o (sc_vld),
    .p_o     (x2),
    .side_o  ({sc_m, sc_flags})
  );

  // root search, one quotient bit per stage, msb first
  // keeps q^2*M and q*M so a trial needs only shifts and adds
  logic [OUT_W-1:0] sq_q   [OUT_W];
  logic [X2W-1:0]   sp_q   [OUT_W];
  logic [QMW-1:0]   sqm_q  [OUT_W];
  logic [MW-1:0]    sm_q   [OUT_W];
  logic [X2W-1:0]   sx2_q  [OUT_W];
  tpc_flags_t       sf_q   [OUT_W];
  logic             svld_q [OUT_W];

  for (genvar j = 0; j < OUT_W; j++) begin : g_root
    localparam int B = OUT_W - 1 - j;

    logic [OUT_W-1:0] q_in;
    logic [X2W-1:0]   p_in;
    logic [QMW-1:0]   qm_in;
    logic [MW-1:0]    m_in;
    logic [X2W-1:0]   x2_in;
    tpc_flags_t       f_in;
    logic             vld_in;
    logic [TW-1:0]    trial;
    logic             take;

    if (j == 0) begin : g_first
      assign q_in   = '0;
      assign p_in   = '0;
      assign qm_in  = '0;
      assign m_in   = sc_m;
      assign x2_in  = x2;
      assign f_in   = sc_flags;
      assign vld_in = sc_vld;
    end else begin : g_next
      assign q_in   = sq_q[j-1];
      assign p_in   = sp_q[j-1];
      assign qm_in  = sqm_q[j-1];
      assign m_in   = sm_q[j-1];
      assign x2_in  = sx2_q[j-1];
      assign f_in   = sf_q[j-1];
      assign vld_in = svld_q[j-1];
    end

    // (q + 2^B)^2 M = q^2 M + 2^(B+1) q M + 2^(2B) M
    assign trial = TW'(p_in) + (TW'(qm_in) << (B + 1)) + (TW'(m_in) << (2 * B));
    assign take  = trial <= TW'(x2_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        svld_q[j] <= 1'b0;
      end else if (ce) begin
        svld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        if (take) begin
          sq_q[j]  <= q_in | (OUT_W'(1) << B);
          sp_q[j]  <= trial[X2W-1:0];
          sqm_q[j] <= qm_in + (QMW'(m_in) << B);
        end else begin
          sq_q[j]  <= q_in;
          sp_q[j]  <= p_in;
          sqm_q[j] <= qm_in;
        end
        sm_q[j]  <= m_in;
        sx2_q[j] <= x2_in;
        sf_q[j]  <= f_in;
      end
    end
  end

  // output: sign, clamp, degenerate override
  logic [OUT_W-1:0]  q_fin, limit, mq;
  logic [OUT_W-1:0]  val_d, val_q;
  logic [USER_W-1:0] user_d, user_q;
  tpc_flags_t        f_fin;
  logic              sat;

  assign q_fin = sq_q[OUT_W-1];
  assign f_fin = sf_q[OUT_W-1];

  always_comb begin
    limit  = f_fin.neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    sat    = q_fin > limit;
    mq     = sat ? limit : q_fin;
    user_d = '0;
    if (f_fin.deg) begin
      val_d                   = '0;
      user_d[USER_DEGENERATE] = 1'b1;
    end else begin
      val_d                  = f_fin.neg ? (OUT_W'(0) - mq) : mq;
      user_d[USER_SATURATED] = sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ce) begin
      out_vld_q <= svld_q[OUT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      val_q  <= val_d;
      user_q <= user_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = val_q;
  assign m_axis_tuser_o  = user_q;

  // a degenerate beat carries zero and is never saturated
  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[USER_DEGENERATE] |->
      (m_axis_tdata_o == '0) && !m_axis_tuser_o[USER_SATURATED])
    else $error("degenerate beat with nonzero curvature or saturation");

  // a saturated beat sits at one end of the range
  a_sat_rail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[USER_SATURATED] |->
      (m_axis_tdata_o == {1'b1, {(OUT_W-1){1'b0}}}) ||
      (m_axis_tdata_o == {1'b0, {(OUT_W-1){1'b1}}}))
    else $error("saturated beat not at a range limit");

  // a stalled output freezes the front of the pipe
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> $stable(vld1_q) && $stable(svld_q[0]))
    else $error("pipe moved while output stalled");

  // no input is taken while the output is stalled
  a_no_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input ready during output stall");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

module testbench
  import tpc_pkg::*;
();

  localparam int COORD_W   = 24;
  localparam int FRAC_W    = 24;
  localparam int IN_W      = 6 * COORD_W;
  localparam int DRAIN_CYC = 80;
  localparam int WDOG_MAX  = 3000;
  localparam int HOLD_CYC  = 300;

  typedef struct {
    logic signed [COORD_W-1:0] first_x, first_y, mid_x, mid_y, last_x, last_y;
    logic                      at_start;
  } window_t;

  typedef struct {
    logic [OUT_W-1:0] curvature;
    logic             degenerate;
    logic             saturated;
  } curv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  // first_x, first_y, mid_x, mid_y, last_x, last_y
  logic [IN_W-1:0]   s_axis_tdata_i = '0;
  // at_start
  logic              s_axis_tuser_i = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  // curvature
  logic [OUT_W-1:0]  m_axis_tdata_o;
  // degenerate, saturated
  logic [USER_W-1:0] m_axis_tuser_o;

  window_t pending_windows[$];
  curv_t   expected_curv[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      error_count = 0;
  int      idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  three_point_curvature dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // exact curvature: largest q with q^2 * s^3 <= (|num| * 2^F)^2, sign applied, clamped
  function automatic curv_t calc_curvature(window_t w);
    longint fx, fy, mx, my, lx, ly, dx, dy, ex, ey, num, mag;
    bit [255:0] rhs, s3, cand;
    bit [63:0] q, t, lim;
    bit neg;
    curv_t r;
    fx = w.first_x; fy = w.first_y;
    mx = w.mid_x;   my = w.mid_y;
    lx = w.last_x;  ly = w.last_y;
    dx = w.at_start ? mx - fx : lx - mx;
    dy = w.at_start ? my - fy : ly - my;
    ex = fx + lx - 2 * mx;
    ey = fy + ly - 2 * my;
    r.curvature = '0;
    r.saturated = 1'b0;
    r.degenerate = (dx == 0 && dy == 0);
    if (r.degenerate) return r;
    num = dx * ey - ex * dy;
    neg = num < 0;
    mag = neg ? -num : num;
    rhs = 256'(mag) << FRAC_W;
    rhs = rhs * rhs;
    s3 = 256'(dx * dx + dy * dy);
    s3 = s3 * s3 * s3;
    q = '0;
    for (int b = OUT_W - 1; b >= 0; b--) begin
      t = q | (64'd1 << b);
      cand = 256'(t);
      cand = cand * cand * s3;
      if (cand <= rhs) q = t;
    end
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (q > lim) begin
      q = lim;
      r.saturated = 1'b1;
    end
    r.curvature = neg ? 32'(-q) : q[31:0];
    return r;
  endfunction

  // append a window to the pending queue
  task automatic queue_window(window_t w);
    pending_windows = {pending_windows, w};
  endtask

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    error_count++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  // sender: one beat offered at a time, fed from the pending queue
  always @(posedge clk_i) begin
    window_t w;
    logic    next_valid;
    if (rst_ni) begin
      next_valid = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        w.first_x = s_axis_tdata_i[0 +: COORD_W];
        w.first_y = s_axis_tdata_i[COORD_W +: COORD_W];
        w.mid_x   = s_axis_tdata_i[2*COORD_W +: COORD_W];
        w.mid_y   = s_axis_tdata_i[3*COORD_W +: COORD_W];
        w.last_x  = s_axis_tdata_i[4*COORD_W +: COORD_W];
        w.last_y  = s_axis_tdata_i[5*COORD_W +: COORD_W];
        w.at_start = s_axis_tuser_i;
        expected_curv = {expected_curv, calc_curvature(w)};
        next_valid = 1'b0;
      end
      if (!next_valid && pending_windows.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        w = pending_windows.pop_front();
        s_axis_tdata_i <= {w.last_y, w.last_x, w.mid_y, w.mid_x, w.first_y, w.first_x};
        s_axis_tuser_i <= w.at_start;
        next_valid = 1'b1;
      end
      s_axis_tvalid_i <= next_valid;
    end
  end

  // receiver: checks each result beat, random stalls and the long hold-off
  always @(posedge clk_i) begin
    curv_t want;
    int    left;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_curv.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata_o, '0);
        end else begin
          want = expected_curv.pop_front();
          if (m_axis_tdata_o !== want.curvature)
            report_mismatch("curvature", m_axis_tdata_o, want.curvature);
          if (m_axis_tuser_o[USER_DEGENERATE] !== want.degenerate)
            report_mismatch("degenerate", 32'(m_axis_tuser_o[USER_DEGENERATE]),
                            32'(want.degenerate));
          if (m_axis_tuser_o[USER_SATURATED] !== want.saturated)
            report_mismatch("saturated", 32'(m_axis_tuser_o[USER_SATURATED]),
                            32'(want.saturated));
        end
      end
      left = hold_left;
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        left = HOLD_CYC;
      end
      if (left > 0) begin
        hold_left <= left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        hold_left <= 0;
        m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] near(logic signed [COORD_W-1:0] base, int r);
    return base + COORD_W'($urandom_range(0, 2 * r) - r);
  endfunction

  // mostly short steps so curvature lands in range, some fully random windows
  function automatic window_t rand_window();
    window_t w;
    int r;
    int mode;
    mode = $urandom_range(0, 9);
    case ($urandom_range(0, 4))
      0: r = $urandom_range(1, 4);
      1: r = 255;
      2: r = 65535;
      3: r = $urandom_range(1, 4095);
      default: r = 1 << 22;
    endcase
    w.first_x = COORD_W'($urandom); w.first_y = COORD_W'($urandom);
    w.at_start = 1'($urandom_range(0, 1));
    if (mode < 2) begin
      w.mid_x = COORD_W'($urandom); w.mid_y = COORD_W'($urandom);
      w.last_x = COORD_W'($urandom); w.last_y = COORD_W'($urandom);
    end else begin
      w.mid_x = near(w.first_x, r); w.mid_y = near(w.first_y, r);
      w.last_x = near(w.mid_x, r);  w.last_y = near(w.mid_y, r);
      // zero first difference now and then
      if (mode == 9) begin
        if (w.at_start) begin
          w.mid_x = w.first_x; w.mid_y = w.first_y;
        end else begin
          w.last_x = w.mid_x; w.last_y = w.mid_y;
        end
      end
    end
    return w;
  endfunction

  function automatic window_t mk(int fx, int fy, int mx, int my, int lx, int ly, bit st);
    window_t w;
    w.first_x = COORD_W'(fx); w.first_y = COORD_W'(fy);
    w.mid_x = COORD_W'(mx); w.mid_y = COORD_W'(my);
    w.last_x = COORD_W'(lx); w.last_y = COORD_W'(ly); w.at_start = st;
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_windows.size() > 0 || s_axis_tvalid_i || expected_curv.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int send_idle, int recv_stall, int count, bit with_hold);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    for (int i = 0; i < count; i++) queue_window(rand_window());
    if (with_hold) hold_req++;
    wait_drained();
  endtask

  initial begin
    localparam int PMAX = 8388607;
    localparam int PMIN = -8388608;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed windows: extremes, degenerate, straight line, saturation both ways
    queue_window(mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 1'b1));
    queue_window(mk(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 1'b0));
    queue_window(mk(PMIN, PMIN, PMAX, PMAX, PMIN, PMIN, 1'b1));
    queue_window(mk(PMIN, PMAX, PMAX, PMIN, PMIN, PMAX, 1'b0));
    queue_window(mk(PMIN, 0, PMAX, 0, PMIN, PMAX, 1'b1));
    queue_window(mk(PMAX, PMIN, 0, 0, PMIN, PMAX, 1'b0));
    queue_window(mk(5, 7, 5, 7, 100, -3, 1'b1));
    queue_window(mk(5, 7, 9, -2, 9, -2, 1'b0));
    queue_window(mk(0, 0, 10, 20, 20, 40, 1'b0));
    queue_window(mk(0, 0, 1, 0, 2, PMAX, 1'b0));
    queue_window(mk(0, 0, 1, 0, 2, PMIN, 1'b0));
    queue_window(mk(0, 0, 0, 1, PMAX, 2, 1'b1));
    queue_window(mk(0, 0, 0, 1, PMIN, 2, 1'b1));
    queue_window(mk(0, 0, 100, 0, 200, 1, 1'b0));
    queue_window(mk(0, 0, 100, 0, 200, -1, 1'b0));
    queue_window(mk(-1, -1, 0, 0, 1, -1, 1'b1));
    queue_window(mk(-3, 4, -1, 5, 2, 3, 1'b0));
    queue_window(mk(PMAX, 0, 0, 0, PMIN, 1, 1'b0));
    wait_drained();

    run_phase(0, 0, 340, 1'b0);
    run_phase(84, 0, 300, 1'b0);
    run_phase(0, 84, 300, 1'b0);
    run_phase(16, 16, 300, 1'b0);
    // long receiver hold-off while the sender keeps offering
    run_phase(0, 0, 200, 1'b1);
    run_phase(16, 16, 260, 1'b1);

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (error_count == 0 && expected_curv.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/tpc_pkg.sv
rtl/tpc_mul.sv
rtl/three_point_curvature.sv
dv/testbench.sv
